>>> rtl/core/aekd_pkg.sv
// Package: shared types and constants of the ANSI escape key decoder.
`default_nettype none
package aekd_pkg;

	// Byte values that steer the decoder
	localparam logic [7:0] BYTE_ESC      = 8'h1B;
	localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
	localparam logic [7:0] BYTE_TILDE    = 8'h7E;
	localparam logic [7:0] BYTE_ZERO     = 8'h30;
	localparam logic [7:0] BYTE_NINE     = 8'h39;
	localparam logic [7:0] BYTE_UPPER_A  = 8'h41;
	localparam logic [7:0] BYTE_UPPER_D  = 8'h44;

	// Key code classes
	localparam logic [15:0] CLASS_META     = 16'h0100;
	localparam logic [15:0] CLASS_NUMBER   = 16'h0200;
	localparam logic [15:0] CLASS_ARROW    = 16'h0400;
	localparam logic [15:0] CLASS_OTHER    = 16'h0800;
	localparam logic [15:0] CODE_MALFORMED = 16'hFFFF;

	// Largest decimal value of a two-digit number
	localparam logic [6:0] NUMBER_MAX = 7'd99;

	// Sequence phase
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ESC     = 3'd1,
		PH_BRACKET = 3'd2,
		PH_DIGIT1  = 3'd3,
		PH_DIGIT2  = 3'd4
	} phase_t;

	// Decoder result for the byte in flight
	typedef struct packed {
		logic   emit;
		logic [15:0] code;
		phase_t phase;
	} decode_t;

endpackage
`default_nettype wire

>>> rtl/core/aekd_decode.sv
// Escape sequence decoder: phase and number registers with next-state and key logic.
`default_nettype none
module aekd_decode (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire logic [7:0]     rx_byte,
	output aekd_pkg::decode_t   result
);
	import aekd_pkg::*;

	phase_t     phase_q;
	phase_t     phase_d;
	logic [6:0] accum_q;
	logic [6:0] accum_d;
	logic       emit;
	logic [15:0] code;
	logic       is_digit;
	logic [6:0] digit_val;
	logic [7:0] digit_off;
	logic [15:0] byte_ext;
	logic [15:0] number_code;

	assign is_digit    = (rx_byte >= BYTE_ZERO) && (rx_byte <= BYTE_NINE);
	assign digit_off   = rx_byte - BYTE_ZERO;
	assign digit_val   = digit_off[6:0];
	assign byte_ext    = {8'h00, rx_byte};
	assign number_code = CLASS_NUMBER | {9'd0, accum_q};

	// Advance the sequence and form the key code
	always_comb begin
		phase_d = PH_IDLE;
		accum_d = '0;
		emit    = 1'b1;
		code    = byte_ext;
		case (phase_q)
			PH_ESC: begin
				if (rx_byte == BYTE_LBRACKET) begin
					phase_d = PH_BRACKET;
					emit    = 1'b0;
				end else begin
					code = CLASS_META | byte_ext;
				end
			end
			PH_BRACKET: begin
				if (is_digit) begin
					phase_d = PH_DIGIT1;
					accum_d = digit_val;
					emit    = 1'b0;
				end else if (rx_byte >= BYTE_UPPER_A && rx_byte <= BYTE_UPPER_D) begin
					code = CLASS_ARROW | byte_ext;
				end else begin
					code = CLASS_OTHER | byte_ext;
				end
			end
			PH_DIGIT1: begin
				if (is_digit) begin
					// times ten as two shifts; at most 99 fits seven bits
					phase_d = PH_DIGIT2;
					accum_d = {accum_q[3:0], 3'b000} + {accum_q[5:0], 1'b0} + digit_val;
					emit    = 1'b0;
				end else begin
					code = (rx_byte == BYTE_TILDE) ? number_code : CODE_MALFORMED;
				end
			end
			PH_DIGIT2: begin
				code = (rx_byte == BYTE_TILDE) ? number_code : CODE_MALFORMED;
			end
			default: begin
				if (rx_byte == BYTE_ESC) begin
					phase_d = PH_ESC;
					emit    = 1'b0;
				end
			end
		endcase
	end

	// Hold state unless a byte is stepped through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			accum_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			accum_q <= accum_d;
		end
	end

	assign result.emit  = emit;
	assign result.code  = code;
	assign result.phase = phase_q;

endmodule
`default_nettype wire

>>> rtl/core/ansi_escape_key_decoder_top.sv
// Top level of the ANSI escape key decoder: input register, decoder, result register.
//
// Usage:
//   s_axis carries one terminal byte per beat (tdata[7:0] = rx_byte).
//   m_axis carries one 16-bit key code per beat (tdata[15:0] = key_code).
//   A plain byte yields itself, ESC x yields 0x100|x, ESC [ A..D yields
//   0x400|letter, ESC [ n ~ (one or two digits) yields 0x200|n, a bad
//   number yields 0xFFFF, any other ESC [ x yields 0x800|x. Bytes that
//   only extend a pending sequence yield no beat.
// Path: a byte accepted on s_axis sits in the input register, is decoded
//   combinationally from it, and its key code (if any) is loaded into the
//   result register, which drives it onto m_axis.
// Throughput: one byte per cycle while no blocked key code stalls the pipe.
// Reset: arst_n clears the phase to idle, the digit accumulator and both
//   valid flags; no beat is pending afterwards.
// Stall: while a key code waits on m_axis with m_axis_tready low, the
//   whole pipe holds and s_axis_tready drops in the same cycle.
`default_nettype none
module ansi_escape_key_decoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata   // [15:0] key_code
);
	import aekd_pkg::*;

	logic        advance;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	logic [15:0] code_s2;
	decode_t     dec;

	// Move the pipe unless a finished beat is blocked
	assign advance       = !(valid_s2 && !m_axis_tready);
	assign s_axis_tready = advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	aekd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance && valid_s1),
		.rx_byte (byte_s1),
		.result  (dec)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && dec.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && dec.emit) begin
			code_s2 <= dec.code;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = code_s2;

	// A blocked result beat stops intake
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while result beat is blocked");

	// A plain byte in idle yields a beat next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && dec.phase == PH_IDLE && byte_s1 != BYTE_ESC)
		|=> m_axis_tvalid)
		else $error("plain byte produced no key code");

	// Upper class bits set only for the malformed code
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[15:12] != 4'h0) |-> (m_axis_tdata == CODE_MALFORMED))
		else $error("bad key code class");

	// A number key stays within two decimal digits
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[15:8] == CLASS_NUMBER[15:8])
		|-> (m_axis_tdata[7:0] <= {1'b0, NUMBER_MAX}))
		else $error("number key out of range");

endmodule
`default_nettype wire
